/* src/paf_pkg.sv */
package paf_pkg;

    localparam int MAX_DELAY  = 1024;
    localparam int PTR_W      = $clog2(MAX_DELAY);
    localparam int LEN_W      = PTR_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FEEDBACK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FEEDFORWARD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY_LEN   = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DELAY);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

endpackage

/* src/paf_sample_if.sv */
interface paf_sample_if;

    logic                                valid;
    logic                                ready;
    logic signed [paf_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);

endinterface

/* src/paf_result_if.sv */
interface paf_result_if;

    logic                                valid;
    logic                                ready;
    logic signed [paf_pkg::SAMPLE_W-1:0] periodic_out;
    logic signed [paf_pkg::SAMPLE_W-1:0] aperiodic_out;

    modport source (output valid, output periodic_out, output aperiodic_out, input ready);
    modport sink   (input valid, input periodic_out, input aperiodic_out, output ready);

endinterface

/* src/periodic_aperiodic_separation_filter.sv */
// path: an accepted sample is registered in stage b, then in stage c, then in the output stage
// throughput: one sample per cycle while result_ch is ready; with delay_len of 1 the feedback
//   through the delay memory holds the input while the previous sample is in stage b or stalled in stage c
// reset: delay memory is not cleared; a fill count marks written entries and
//   unwritten entries read as zero, so samples are accepted right after reset
module periodic_aperiodic_separation_filter
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    paf_sample_if.sink                            sample_ch,
    paf_result_if.source                          result_ch,
    input  logic                                  cfg_we,
    input  logic [paf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [paf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int SW    = paf_pkg::SAMPLE_W;
    localparam int PW    = paf_pkg::PTR_W;
    localparam int LW    = paf_pkg::LEN_W;
    localparam int CW    = paf_pkg::COEF_W;
    localparam int FBW   = CW + SW;
    localparam int FFW   = CW + SW + 1;
    localparam int ACCW  = FFW + 1;
    localparam int RNDW  = ACCW - paf_pkg::FRAC_W;

    localparam logic signed [RNDW-1:0] RND_HI = RNDW'((2 ** (SW - 1)) - 1);
    localparam logic signed [RNDW-1:0] RND_LO = -RNDW'(2 ** (SW - 1));
    localparam logic signed [SW:0]     DIF_HI = (SW + 1)'((2 ** (SW - 1)) - 1);
    localparam logic signed [SW:0]     DIF_LO = -(SW + 1)'(2 ** (SW - 1));
    localparam logic signed [ACCW-1:0] HALF   = ACCW'(2 ** (paf_pkg::FRAC_W - 1));

    // configuration
    logic signed [CW-1:0] coef_fb_reg;
    logic signed [CW-1:0] coef_ff_reg;
    logic [LW-1:0]        delay_len_reg;
    logic [LW-1:0]        len_wr;

    // pointer and fill count
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [PW-1:0] cur_ptr;
    logic [LW-1:0] ptr_inc;
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_next;

    // memory, {sample, periodic}
    logic [2*SW-1:0] mem [paf_pkg::MAX_DELAY];
    logic [2*SW-1:0] rd_data_reg;
    logic            rd_ok_reg;

    // last write, for read-during-write forwarding
    logic          wr_valid_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [SW-1:0] wr_x_reg;
    logic [SW-1:0] wr_per_reg;

    // stage b
    logic                 valid_b_reg;
    logic [PW-1:0]        ptr_b_reg;
    logic signed [SW-1:0] x_b_reg;
    logic signed [SW-1:0] xd;
    logic signed [SW-1:0] pd;
    logic                 fwd;
    logic signed [SW:0]   xsum;
    logic signed [FBW-1:0] prod_fb;
    logic signed [FFW-1:0] prod_ff;

    // stage c
    logic                  valid_c_reg;
    logic [PW-1:0]         ptr_c_reg;
    logic signed [SW-1:0]  x_c_reg;
    logic signed [FBW-1:0] prod_fb_reg;
    logic signed [FFW-1:0] prod_ff_reg;
    logic signed [ACCW-1:0] acc;
    logic signed [RNDW-1:0] rnd;
    logic signed [SW-1:0]  per;
    logic signed [SW:0]    dif;
    logic signed [SW-1:0]  aper;

    // output stage
    logic                 out_valid_reg;
    logic signed [SW-1:0] per_out_reg;
    logic signed [SW-1:0] aper_out_reg;

    logic out_en;
    logic c_en;
    logic b_en;
    logic hazard;
    logic accept;
    logic wr_en;

    // flow control
    always_comb
    begin
        out_en = !out_valid_reg || result_ch.ready;
        c_en   = !valid_c_reg || out_en;
        b_en   = !valid_b_reg || c_en;
        // entry still owed by an older transaction
        hazard = (valid_b_reg && (ptr_b_reg == cur_ptr))
              || (valid_c_reg && !out_en && (ptr_c_reg == cur_ptr));
        accept = sample_ch.valid && b_en && !hazard;
        wr_en  = valid_c_reg && out_en;
    end

    assign sample_ch.ready         = b_en && !hazard;
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.periodic_out  = per_out_reg;
    assign result_ch.aperiodic_out = aper_out_reg;

    // pointer
    always_comb
    begin
        cur_ptr  = ({1'b0, ptr_reg} >= delay_len_reg) ? '0 : ptr_reg;
        ptr_inc  = {1'b0, cur_ptr} + LW'(1);
        ptr_next = (ptr_inc >= delay_len_reg) ? '0 : ptr_inc[PW-1:0];
        fill_next = fill_reg;
        if (wr_en && ({1'b0, ptr_c_reg} == fill_reg))
        begin
            fill_next = fill_reg + LW'(1);
        end
    end

    always_comb
    begin
        len_wr = cfg_data[LW-1:0];
        if (len_wr == '0)
        begin
            len_wr = paf_pkg::LEN_MIN;
        end
        else if (len_wr > paf_pkg::LEN_MAX)
        begin
            len_wr = paf_pkg::LEN_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_fb_reg   <= '0;
            coef_ff_reg   <= '0;
            delay_len_reg <= paf_pkg::LEN_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                paf_pkg::CFG_IDX_FEEDBACK:    coef_fb_reg   <= cfg_data[CW-1:0];
                paf_pkg::CFG_IDX_FEEDFORWARD: coef_ff_reg   <= cfg_data[CW-1:0];
                paf_pkg::CFG_IDX_DELAY_LEN:   delay_len_reg <= len_wr;
                default:                      ;
            endcase
        end
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_c_reg] <= {x_c_reg, per};
        end
        if (accept)
        begin
            rd_data_reg <= mem[cur_ptr];
        end
    end

    // stage b: operand select and products
    always_comb
    begin
        fwd = wr_valid_reg && (wr_ptr_reg == ptr_b_reg);
        if (fwd)
        begin
            xd = wr_x_reg;
            pd = wr_per_reg;
        end
        else if (rd_ok_reg)
        begin
            xd = rd_data_reg[2*SW-1:SW];
            pd = rd_data_reg[SW-1:0];
        end
        else
        begin
            xd = '0;
            pd = '0;
        end
        xsum    = {x_b_reg[SW-1], x_b_reg} + {xd[SW-1], xd};
        prod_fb = coef_fb_reg * pd;
        prod_ff = coef_ff_reg * xsum;
    end

    // stage c: sum, round, saturate, then the saturated aperiodic difference
    always_comb
    begin
        acc = ACCW'(prod_fb_reg) + ACCW'(prod_ff_reg) + HALF;
        rnd = acc[ACCW-1:paf_pkg::FRAC_W];
        if (rnd > RND_HI)
        begin
            per = RND_HI[SW-1:0];
        end
        else if (rnd < RND_LO)
        begin
            per = RND_LO[SW-1:0];
        end
        else
        begin
            per = rnd[SW-1:0];
        end
        dif = {x_c_reg[SW-1], x_c_reg} - {per[SW-1], per};
        if (dif > DIF_HI)
        begin
            aper = DIF_HI[SW-1:0];
        end
        else if (dif < DIF_LO)
        begin
            aper = DIF_LO[SW-1:0];
        end
        else
        begin
            aper = dif[SW-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            fill_reg      <= '0;
            wr_valid_reg  <= 1'b0;
            valid_b_reg   <= 1'b0;
            valid_c_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                ptr_reg <= ptr_next;
            end
            if (wr_en)
            begin
                wr_valid_reg <= 1'b1;
            end
            if (b_en)
            begin
                valid_b_reg <= accept;
            end
            if (c_en)
            begin
                valid_c_reg <= valid_b_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= valid_c_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ptr_b_reg <= cur_ptr;
            x_b_reg   <= sample_ch.sample_in;
            rd_ok_reg <= ({1'b0, cur_ptr} < fill_reg);
        end
        if (c_en && valid_b_reg)
        begin
            ptr_c_reg   <= ptr_b_reg;
            x_c_reg     <= x_b_reg;
            prod_fb_reg <= prod_fb;
            prod_ff_reg <= prod_ff;
        end
        if (wr_en)
        begin
            wr_ptr_reg   <= ptr_c_reg;
            wr_x_reg     <= x_c_reg;
            wr_per_reg   <= per;
            per_out_reg  <= per;
            aper_out_reg <= aper;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= paf_pkg::LEN_MAX)
        else $error("fill count beyond memory depth");

    a_write_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, ptr_c_reg} <= fill_reg))
        else $error("write leaves a gap above the fill count");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (delay_len_reg >= paf_pkg::LEN_MIN) && (delay_len_reg <= paf_pkg::LEN_MAX))
        else $error("delay length out of range");

    a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(valid_b_reg && (ptr_b_reg == cur_ptr)))
        else $error("read of an entry still owed by stage b");

endmodule

/* tb/paf_separation_monitor.sv */
module paf_separation_monitor
    import paf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    input  logic                       sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       result_valid,
    input  logic                       result_ready,
    input  logic signed [SAMPLE_W-1:0] periodic_out,
    input  logic signed [SAMPLE_W-1:0] aperiodic_out,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int unsigned                mismatch_count,
    output int unsigned                pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] periodic;
        logic signed [SAMPLE_W-1:0] aperiodic;
    } separation_t;

    separation_t                expected_q[$];
    logic signed [SAMPLE_W-1:0] input_hist[MAX_DELAY];
    logic signed [SAMPLE_W-1:0] periodic_hist[MAX_DELAY];
    int unsigned                hist_ptr;
    int unsigned                period_len;
    logic signed [COEF_W-1:0]   fb_coef;
    logic signed [COEF_W-1:0]   ff_coef;

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return SAMPLE_W'(hi);
        end
        if (v < lo)
        begin
            return SAMPLE_W'(lo);
        end
        return SAMPLE_W'(v);
    endfunction

    function automatic separation_t separate(input logic signed [SAMPLE_W-1:0] x);
        separation_t r;
        longint      acc;
        if (hist_ptr >= period_len)
        begin
            hist_ptr = 0;
        end
        acc = longint'(fb_coef) * longint'(periodic_hist[hist_ptr])
            + longint'(ff_coef) * (longint'(x) + longint'(input_hist[hist_ptr]));
        // round half up, then drop the fraction
        r.periodic  = clamp_sample((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
        r.aperiodic = clamp_sample(longint'(x) - longint'(r.periodic));
        input_hist[hist_ptr]    = x;
        periodic_hist[hist_ptr] = r.periodic;
        hist_ptr = hist_ptr + 1;
        if (hist_ptr >= period_len)
        begin
            hist_ptr = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        separation_t want;
        int unsigned len_word;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DELAY; i++)
            begin
                input_hist[i]    = '0;
                periodic_hist[i] = '0;
            end
            hist_ptr       = 0;
            period_len     = MAX_DELAY;
            fb_coef        = '0;
            ff_coef        = '0;
            mismatch_count = 0;
            expected_q.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_FEEDBACK:    fb_coef = cfg_data[COEF_W-1:0];
                    CFG_IDX_FEEDFORWARD: ff_coef = cfg_data[COEF_W-1:0];
                    CFG_IDX_DELAY_LEN:
                    begin
                        len_word = 32'(cfg_data[LEN_W-1:0]);
                        if (len_word == 0)
                        begin
                            len_word = 1;
                        end
                        if (len_word > MAX_DELAY)
                        begin
                            len_word = MAX_DELAY;
                        end
                        period_len = len_word;
                    end
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                expected_q.push_back(separate(sample_in));
            end
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("%0t: unexpected result transaction periodic=%0d aperiodic=%0d",
                                 $realtime, periodic_out, aperiodic_out);
                    end
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (periodic_out !== want.periodic || aperiodic_out !== want.aperiodic)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("%0t: periodic exp %0d got %0d, aperiodic exp %0d got %0d",
                                     $realtime, want.periodic, periodic_out,
                                     want.aperiodic, aperiodic_out);
                        end
                        mismatch_count++;
                    end
                end
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import paf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_req      = 1'b0;
    logic        hold_done;
    int          quiet_cycles  = 0;
    int unsigned mismatch_count;
    int unsigned pending_count;
    int          base_wave[MAX_DELAY];

    paf_sample_if sample_bus ();
    paf_result_if result_bus ();

    periodic_aperiodic_separation_filter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    paf_separation_monitor separation_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_bus.valid),
        .sample_ready   (sample_bus.ready),
        .sample_in      (sample_bus.sample_in),
        .result_valid   (result_bus.valid),
        .result_ready   (result_bus.ready),
        .periodic_out   (result_bus.periodic_out),
        .aperiodic_out  (result_bus.aperiodic_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
            || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        result_bus.ready <= 1'b0;
        hold_done        <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done <= 1'b1;
            end
            result_bus.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid     <= 1'b1;
        sample_bus.sample_in <= v;
        @(posedge clk);
        while (sample_bus.ready !== 1'b1)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input int fb, input int ff, input int len_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= CFG_IDX_FEEDBACK;
        cfg_data  <= CFG_DATA_W'(fb);
        @(posedge clk);
        cfg_index <= CFG_IDX_FEEDFORWARD;
        cfg_data  <= CFG_DATA_W'(ff);
        @(posedge clk);
        cfg_index <= CFG_IDX_DELAY_LEN;
        cfg_data  <= CFG_DATA_W'(len_word);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int done, output int n);
        int  sel;
        int  fb;
        int  ff;
        int  len_word;
        int  period;
        int  nz;
        int  w;
        bit  noisy;
        if (done < RANDOM_ITEMS / 3)
        begin
            send_idle_pct <= 33;
            recv_idle_pct <= 80;
        end
        else if (done < 2 * RANDOM_ITEMS / 3)
        begin
            send_idle_pct <= 80;
            recv_idle_pct <= 33;
        end
        else
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
        if (done >= 150 && !hold_req)
        begin
            hold_req <= 1'b1;
        end
        sel = $urandom_range(9);
        if (sel < 7)
        begin
            // stable filter: feedback below one, feedforward about half the rest
            fb = $urandom_range(65535, 32768);
            ff = (65536 - fb) / 2 + int'($urandom_range(8)) - 4;
        end
        else if (sel < 9)
        begin
            fb = $urandom;
            ff = $urandom;
        end
        else
        begin
            fb = $urandom_range(1) ? 131071 : -131072;
            ff = $urandom_range(1) ? 131071 : -131072;
        end
        sel = $urandom_range(9);
        if (sel < 4)
        begin
            len_word = $urandom_range(8, 1);
        end
        else if (sel < 8)
        begin
            len_word = $urandom_range(300, 9);
        end
        else if (sel == 8)
        begin
            len_word = int'(LEN_MAX);
        end
        else
        begin
            len_word = $urandom_range(2047);
        end
        period = (len_word == 0) ? 1 : ((len_word > MAX_DELAY) ? MAX_DELAY : len_word);
        configure(fb, ff, len_word | (int'($urandom_range(127)) << LEN_W));
        for (int i = 0; i < period; i++)
        begin
            base_wave[i] = int'($urandom_range(40000)) - 20000;
        end
        nz    = $urandom_range(2000);
        noisy = ($urandom_range(3) == 0);
        n     = $urandom_range(90, 30);
        for (int i = 0; i < n; i++)
        begin
            if (noisy || $urandom_range(19) == 0)
            begin
                send_sample(SAMPLE_W'($urandom));
            end
            else
            begin
                w = base_wave[i % period] + int'($urandom_range(2 * nz)) - nz;
                send_sample(SAMPLE_W'(w));
            end
        end
        wait_results_drained();
    endtask

    initial
    begin
        int done;
        int n;
        rst_n                 = 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_IDX_FEEDBACK;
        cfg_data             <= '0;
        sample_bus.valid     <= 1'b0;
        sample_bus.sample_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct <= 33;
        recv_idle_pct <= 80;

        // largest coefficients, short period: saturation both ways
        configure(131071, 131071, 2);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd32767);
        wait_results_drained();

        // most negative coefficients, one sample period
        configure(-131072, -131072, int'(LEN_MIN));
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(16'sd0);
        wait_results_drained();

        // zero period treated as one, half-lsb rounding ties
        configure(0, 32768, 0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        wait_results_drained();

        // period above the maximum is clipped
        configure(58982, 3277, 2047);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd12345);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        wait_results_drained();

        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            random_phase(done, n);
            done += n;
        end

        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
